// ----- design/sfg_pkg.sv -----
// ----------------------------------------------------------------------------
// sfg_pkg
// Shared types, command codes and helpers of the set factor gradient unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sfg_pkg;

   // divider geometry
   localparam int DivBits   = 47;
   localparam int DivorBits = 15;

   // shared multiplier operand selection
   localparam logic [2:0] MUL_NONE = 3'd0;
   localparam logic [2:0] MUL_LOAD = 3'd1;
   localparam logic [2:0] MUL_DA   = 3'd2;
   localparam logic [2:0] MUL_DD   = 3'd3;
   localparam logic [2:0] MUL_ST   = 3'd4;
   localparam logic [2:0] MUL_TU   = 3'd5;
   localparam logic [2:0] MUL_CLO  = 3'd6;
   localparam logic [2:0] MUL_CHI  = 3'd7;

   // divider operand selection
   localparam logic [1:0] DIV_DOT = 2'd0;
   localparam logic [1:0] DIV_T   = 2'd1;
   localparam logic [1:0] DIV_C   = 2'd2;

   typedef struct packed {
      logic       load;
      logic       latch;
      logic [2:0] mul_op;
      logic       div_start;
      logic [1:0] div_sel;
      logic       d_load;
      logic       t_load;
      logic       c_load;
      logic       coef_clear;
      logic       ug_load;
      logic       acc_load;
      logic       acc_add;
      logic       acc_add_hi;
      logic       out_load;
      logic       idx_inc;
      logic       run_clear;
   } cmd_type;

   typedef struct packed {
      logic size_err;
      logic idx_last;
      logic out_free;
   } status_type;

   // divide by 2^14 rounding toward zero, then clamp to 32 bits
   function automatic logic signed [31:0] sat_q14(input logic signed [71:0] v);
      logic signed [71:0] adj;
      logic signed [71:0] q;
      adj = v + $signed({58'b0, {14{v[71]}}});
      q   = adj >>> 14;
      if (q > 72'sd2147483647) begin
         return 32'h7fffffff;
      end else if (q < -72'sd2147483648) begin
         return 32'h80000000;
      end else begin
         return q[31:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- design/sfg_div.sv -----
// ----------------------------------------------------------------------------
// sfg_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfg_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [sfg_pkg::DivBits-1:0]       dividend,
   input  wire logic [sfg_pkg::DivorBits-1:0]     divisor,
   output logic                                   done,
   output logic [sfg_pkg::DivBits-1:0]            quotient
);

   logic [sfg_pkg::DivBits-1:0]   quo_ff;
   logic [sfg_pkg::DivorBits:0]   rem_ff;
   logic [sfg_pkg::DivorBits-1:0] dvr_ff;
   logic [5:0]                    cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [sfg_pkg::DivorBits:0]   shifted;
   logic [sfg_pkg::DivorBits+1:0] trial;
   logic                          ge;

   always_comb begin
      shifted = {rem_ff[sfg_pkg::DivorBits-1:0], quo_ff[sfg_pkg::DivBits-1]};
      trial   = {1'b0, shifted} - {2'b0, dvr_ff};
      ge      = !trial[sfg_pkg::DivorBits+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= 6'(sfg_pkg::DivBits);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? trial[sfg_pkg::DivorBits:0] : shifted;
         quo_ff <= {quo_ff[sfg_pkg::DivBits-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- design/sfg_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfg_ctrl
// Sequencer: load phase, coefficient set-up and per-element emit pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sfg_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic                req_tlast,
   output logic                     req_tready,
   input  wire logic                div_done,
   input  wire sfg_pkg::status_type status,
   output sfg_pkg::cmd_type         cmd
);

   localparam logic [4:0] S_LOAD   = 5'd0;
   localparam logic [4:0] S_SETTLE = 5'd1;
   localparam logic [4:0] S_DIV1   = 5'd2;
   localparam logic [4:0] S_WAIT1  = 5'd3;
   localparam logic [4:0] S_MULA   = 5'd4;
   localparam logic [4:0] S_DIV2   = 5'd5;
   localparam logic [4:0] S_WAIT2  = 5'd6;
   localparam logic [4:0] S_MULD   = 5'd7;
   localparam logic [4:0] S_DIV3   = 5'd8;
   localparam logic [4:0] S_WAIT3  = 5'd9;
   localparam logic [4:0] S_RD     = 5'd10;
   localparam logic [4:0] S_P1     = 5'd11;
   localparam logic [4:0] S_P2     = 5'd12;
   localparam logic [4:0] S_P3     = 5'd13;
   localparam logic [4:0] S_P4     = 5'd14;
   localparam logic [4:0] S_P5     = 5'd15;
   localparam logic [4:0] S_OUT    = 5'd16;

   logic [4:0] state_ff;
   logic [4:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == S_LOAD);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd        = '0;
      cmd.mul_op = sfg_pkg::MUL_NONE;
      state_in   = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               cmd.load   = 1'b1;
               cmd.mul_op = sfg_pkg::MUL_LOAD;
               if (req_tlast) begin
                  cmd.latch = 1'b1;
                  state_in  = S_SETTLE;
               end
            end
         end
         S_SETTLE: begin
            if (status.size_err) begin
               cmd.coef_clear = 1'b1;
               state_in       = S_RD;
            end else begin
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = sfg_pkg::DIV_DOT;
            state_in      = S_WAIT1;
         end
         S_WAIT1: begin
            if (div_done) begin
               cmd.d_load = 1'b1;
               state_in   = S_MULA;
            end
         end
         S_MULA: begin
            cmd.mul_op = sfg_pkg::MUL_DA;
            state_in   = S_DIV2;
         end
         S_DIV2: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = sfg_pkg::DIV_T;
            state_in      = S_WAIT2;
         end
         S_WAIT2: begin
            if (div_done) begin
               cmd.t_load = 1'b1;
               state_in   = S_MULD;
            end
         end
         S_MULD: begin
            cmd.mul_op = sfg_pkg::MUL_DD;
            state_in   = S_DIV3;
         end
         S_DIV3: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = sfg_pkg::DIV_C;
            state_in      = S_WAIT3;
         end
         S_WAIT3: begin
            if (div_done) begin
               cmd.c_load = 1'b1;
               state_in   = S_RD;
            end
         end
         S_RD: begin
            state_in = S_P1;
         end
         S_P1: begin
            cmd.mul_op = sfg_pkg::MUL_ST;
            state_in   = S_P2;
         end
         S_P2: begin
            cmd.ug_load = 1'b1;
            cmd.mul_op  = sfg_pkg::MUL_TU;
            state_in    = S_P3;
         end
         S_P3: begin
            cmd.acc_load = 1'b1;
            cmd.mul_op   = sfg_pkg::MUL_CLO;
            state_in     = S_P4;
         end
         S_P4: begin
            cmd.acc_add = 1'b1;
            cmd.mul_op  = sfg_pkg::MUL_CHI;
            state_in    = S_P5;
         end
         S_P5: begin
            cmd.acc_add_hi = 1'b1;
            state_in       = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.idx_last) begin
                  cmd.run_clear = 1'b1;
                  state_in      = S_LOAD;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/sfg_dp.sv -----
// ----------------------------------------------------------------------------
// sfg_dp
// Datapath: element stores, dot accumulator, shared multiplier, coefficient
// registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfg_dp #(
   parameter int FACTOR_DIM = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire sfg_pkg::cmd_type                   cmd,
   output sfg_pkg::status_type                     status,
   input  wire logic signed [15:0]                 user_factor,
   input  wire logic signed [21:0]                 sum_factor,
   input  wire logic signed [15:0]                 item_factor,
   input  wire logic [7:0]                         set_size,
   input  wire logic signed [15:0]                 avg_similarity,
   input  wire logic signed [17:0]                 rating,
   output logic [sfg_pkg::DivBits-1:0]             div_dividend,
   output logic [sfg_pkg::DivorBits-1:0]           div_divisor,
   input  wire logic [sfg_pkg::DivBits-1:0]        div_quotient,
   input  wire logic                               rsp_tready,
   output logic                                    rsp_tvalid,
   output logic [5:0]                              element_index,
   output logic signed [31:0]                      user_grad,
   output logic signed [31:0]                      item_grad,
   output logic                                    size_error,
   output logic                                    last_out
);

   localparam int CW = $clog2(FACTOR_DIM + 1);
   localparam int IW = (FACTOR_DIM > 1) ? $clog2(FACTOR_DIM) : 1;

   logic signed [15:0] user_mem [FACTOR_DIM];
   logic signed [21:0] sum_mem  [FACTOR_DIM];
   logic signed [15:0] item_mem [FACTOR_DIM];

   logic signed [15:0] u_rd_ff;
   logic signed [21:0] s_rd_ff;
   logic signed [15:0] i_rd_ff;

   logic [CW-1:0]      count_ff;
   logic [IW-1:0]      idx_ff;
   logic signed [47:0] dot_ff;
   logic               acc_pend_ff;
   logic               store_ok;

   logic [7:0]         size_ff;
   logic signed [15:0] avg_ff;
   logic signed [17:0] rating_ff;

   logic signed [34:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [66:0] mul_p;
   logic signed [66:0] prod_ff;

   logic               sgn_ff;
   logic signed [31:0] d_ff;
   logic signed [33:0] t_ff;
   logic [46:0]        c_ff;
   logic signed [31:0] ug_ff;
   logic signed [71:0] acc_ff;
   logic signed [22:0] diff;

   logic [47:0]        dot_mag;
   logic [66:0]        prod_mag;
   logic [15:0]        size_sq;
   logic signed [47:0] q_signed;
   logic signed [47:0] r_sh;
   logic signed [47:0] d28;
   logic signed [47:0] d_adj;
   logic signed [33:0] q_t;

   logic               rsp_valid_ff;
   logic [5:0]         idx_out_ff;
   logic signed [31:0] ug_out_ff;
   logic signed [31:0] ig_out_ff;
   logic               err_out_ff;
   logic               last_out_ff;

   assign store_ok = (count_ff < CW'(FACTOR_DIM));
   assign diff     = 23'(s_rd_ff) - 23'(i_rd_ff);

   // element stores
   always_ff @(posedge clock) begin
      if (cmd.load && store_ok) begin
         user_mem[count_ff[IW-1:0]] <= user_factor;
         sum_mem[count_ff[IW-1:0]]  <= sum_factor;
         item_mem[count_ff[IW-1:0]] <= item_factor;
      end
      u_rd_ff <= user_mem[idx_ff];
      s_rd_ff <= sum_mem[idx_ff];
      i_rd_ff <= item_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         idx_ff      <= '0;
         dot_ff      <= '0;
         acc_pend_ff <= 1'b0;
      end else begin
         acc_pend_ff <= cmd.load && store_ok;
         if (cmd.run_clear) begin
            count_ff <= '0;
            idx_ff   <= '0;
            dot_ff   <= '0;
         end else begin
            if (cmd.load && store_ok) begin
               count_ff <= count_ff + CW'(1);
            end
            if (cmd.idx_inc) begin
               idx_ff <= idx_ff + IW'(1);
            end
            if (acc_pend_ff) begin
               dot_ff <= dot_ff + prod_ff[47:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         size_ff   <= set_size;
         avg_ff    <= avg_similarity;
         rating_ff <= rating;
      end
   end

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         sfg_pkg::MUL_LOAD: begin
            mul_a = 35'(user_factor);
            mul_b = 32'(sum_factor);
         end
         sfg_pkg::MUL_DA: begin
            mul_a = 35'(d_ff);
            mul_b = 32'(avg_ff);
         end
         sfg_pkg::MUL_DD: begin
            mul_a = 35'(d_ff);
            mul_b = d_ff;
         end
         sfg_pkg::MUL_ST: begin
            mul_a = 35'(t_ff);
            mul_b = 32'(s_rd_ff);
         end
         sfg_pkg::MUL_TU: begin
            mul_a = 35'(t_ff);
            mul_b = 32'(u_rd_ff);
         end
         sfg_pkg::MUL_CLO: begin
            mul_a = $signed({12'b0, c_ff[22:0]});
            mul_b = 32'(diff);
         end
         sfg_pkg::MUL_CHI: begin
            mul_a = $signed({11'b0, c_ff[46:23]});
            mul_b = 32'(diff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = 67'(mul_a) * 67'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_op != sfg_pkg::MUL_NONE) begin
         prod_ff <= mul_p;
      end
   end

   // divider operands, all magnitudes
   always_comb begin
      dot_mag  = dot_ff[47] ? 48'(-dot_ff) : 48'(dot_ff);
      prod_mag = prod_ff[66] ? 67'(-prod_ff) : 67'(prod_ff);
      size_sq  = 16'(size_ff) * 16'(size_ff - 8'd1);
      case (cmd.div_sel)
         sfg_pkg::DIV_DOT: begin
            div_dividend = dot_mag[46:0];
            div_divisor  = {7'b0, size_ff};
         end
         sfg_pkg::DIV_T: begin
            // twice the product, then the 2^14 scale
            div_dividend = prod_mag[59:13];
            div_divisor  = {7'b0, size_ff};
         end
         sfg_pkg::DIV_C: begin
            div_dividend = prod_mag[60:14];
            div_divisor  = size_sq[15:1];
         end
         default: begin
            div_dividend = '0;
            div_divisor  = {7'b0, size_ff};
         end
      endcase
   end

   // coefficient forming
   always_comb begin
      q_signed = sgn_ff ? -$signed({1'b0, div_quotient})
                        : $signed({1'b0, div_quotient});
      r_sh     = $signed({{16{rating_ff[17]}}, rating_ff, 14'b0});
      d28      = r_sh - q_signed;
      d_adj    = d28 + $signed({34'b0, {14{d28[47]}}});
      q_t      = $signed({1'b0, div_quotient[32:0]});
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         case (cmd.div_sel)
            sfg_pkg::DIV_DOT: sgn_ff <= dot_ff[47];
            sfg_pkg::DIV_T:   sgn_ff <= prod_ff[66];
            default:          sgn_ff <= 1'b0;
         endcase
      end
      if (cmd.d_load) begin
         d_ff <= d_adj[45:14];
      end
      if (cmd.coef_clear) begin
         t_ff <= '0;
         c_ff <= '0;
      end else begin
         if (cmd.t_load) begin
            t_ff <= sgn_ff ? q_t : -q_t;
         end
         if (cmd.c_load) begin
            c_ff <= div_quotient;
         end
      end
      if (cmd.ug_load) begin
         ug_ff <= sfg_pkg::sat_q14(72'(prod_ff));
      end
      if (cmd.acc_load) begin
         acc_ff <= 72'(prod_ff);
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + 72'(prod_ff);
      end else if (cmd.acc_add_hi) begin
         // high part of the split coefficient
         acc_ff <= acc_ff + (72'(prod_ff) <<< 23);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         idx_out_ff  <= 6'(idx_ff);
         ug_out_ff   <= ug_ff;
         ig_out_ff   <= sfg_pkg::sat_q14(acc_ff);
         err_out_ff  <= status.size_err;
         last_out_ff <= status.idx_last;
      end
   end

   always_comb begin
      status.size_err = (size_ff < 8'd2);
      status.idx_last = (CW'(idx_ff) == count_ff - CW'(1));
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign element_index = idx_out_ff;
   assign user_grad     = ug_out_ff;
   assign item_grad     = ig_out_ff;
   assign size_error    = err_out_ff;
   assign last_out      = last_out_ff;

endmodule

`default_nettype wire

// ----- design/set_factor_gradient_unit.sv -----
// ----------------------------------------------------------------------------
// set_factor_gradient_unit
// Per-element user and item gradients for a set preference factor model.
// ----------------------------------------------------------------------------
// Factor elements stream in one per cycle with req_tready held high; each is
// stored (up to FACTOR_DIM, extras are dropped) and its user-by-sum product is
// accumulated. The element marked with tlast also carries set size, rating and
// average similarity and ends the run. Set-up then runs three passes of the
// shared bit-serial divider (for dot/size, the similarity term and the pair
// coefficient); a set size below 2 skips them and gives zero gradients with
// the error flag in tuser. Each result then takes the four products of the
// shared multiplier and waits at the output while rsp_tready is low. No new
// element is taken until the final result of a run has been loaded into the
// output register.
`default_nettype none

module set_factor_gradient_unit #(
   parameter int FACTOR_DIM = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // user_factor[15:0], sum_factor[37:16], item_factor[53:38], set_size[61:54],
   // avg_similarity[77:62], rating[95:78]
   input  wire logic [95:0] req_tdata,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // element_index[5:0], user_grad[37:6], item_grad[69:38], zero pad [71:70]
   output logic [71:0]      rsp_tdata,
   // size_error[0]
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   sfg_pkg::cmd_type    cmd;
   sfg_pkg::status_type status;

   logic                                div_done;
   logic [sfg_pkg::DivBits-1:0]         div_dividend;
   logic [sfg_pkg::DivorBits-1:0]       div_divisor;
   logic [sfg_pkg::DivBits-1:0]         div_quotient;
   logic [5:0]                          element_index;
   logic signed [31:0]                  user_grad;
   logic signed [31:0]                  item_grad;

   sfg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .div_done   (div_done),
      .status     (status),
      .cmd        (cmd)
   );

   sfg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   sfg_dp #(
      .FACTOR_DIM (FACTOR_DIM)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .user_factor    ($signed(req_tdata[15:0])),
      .sum_factor     ($signed(req_tdata[37:16])),
      .item_factor    ($signed(req_tdata[53:38])),
      .set_size       (req_tdata[61:54]),
      .avg_similarity ($signed(req_tdata[77:62])),
      .rating         ($signed(req_tdata[95:78])),
      .div_dividend   (div_dividend),
      .div_divisor    (div_divisor),
      .div_quotient   (div_quotient),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .element_index  (element_index),
      .user_grad      (user_grad),
      .item_grad      (item_grad),
      .size_error     (rsp_tuser),
      .last_out       (rsp_tlast)
   );

   assign rsp_tdata = {2'b0, item_grad, user_grad, element_index};

`ifndef SYNTHESIS
   // a run in progress holds off new elements
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("element taken right after end of run");

   // a waiting result transaction holds still
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while waiting");

   // small sets give zero gradients
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (user_grad == 32'sd0) && (item_grad == 32'sd0))
      else $error("non-zero gradient on size error");
`endif

endmodule

`default_nettype wire

// ----- tb/set_factor_gradient_unit_test.sv -----
// ----------------------------------------------------------------------------
// set_factor_gradient_unit_test
// Self-checking bench: directed table then random factor vectors, every result
// transaction compared with a gradient predictor under random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module set_factor_gradient_unit_test;

   localparam int Dim       = 32;
   localparam int CycleMax  = 1500000;
   localparam int TableSize = 14;

   typedef struct packed {
      logic signed [15:0] user_f;
      logic signed [21:0] sum_f;
      logic signed [15:0] item_f;
      logic        [7:0]  set_size;
      logic signed [15:0] avg_sim;
      logic signed [17:0] rating;
      logic               last;
   } element_type;

   typedef struct packed {
      logic [5:0]         index;
      logic signed [31:0] user_grad;
      logic signed [31:0] item_grad;
      logic               size_err;
      logic               last;
   } gradient_type;

   // directed rows: count of elements, fill pattern, set size, similarity, rating
   typedef struct {
      int          count;
      int          pattern;
      logic [7:0]  set_size;
      logic [15:0] avg_sim;
      logic [17:0] rating;
   } vector_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   set_factor_gradient_unit #(.FACTOR_DIM(Dim)) dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   logic signed [15:0] user_mem [Dim];
   logic signed [21:0] sum_mem  [Dim];
   logic signed [15:0] item_mem [Dim];
   longint             dot_sum;
   int                 stored;
   gradient_type       gradients_due [$];
   int                 errors = 0;
   int                 cycles = 0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   task automatic predict_gradients(element_type e);
      longint s, pairs, d14, t14, c14, su, ug, ig;
      bit     err;
      gradient_type g;
      if (stored < Dim) begin
         user_mem[stored] = e.user_f;
         sum_mem[stored]  = e.sum_f;
         item_mem[stored] = e.item_f;
         dot_sum += longint'(e.user_f) * longint'(e.sum_f);
         stored++;
      end
      if (!e.last) return;
      s = e.set_size;
      err = s < 2;
      t14 = 0;
      c14 = 0;
      if (!err) begin
         pairs = (s * (s - 1)) / 2;
         d14 = (longint'(e.rating) * 16384 - dot_sum / s) / 16384;
         t14 = -((2 * d14 * longint'(e.avg_sim)) / (s * 16384));
         c14 = (d14 * d14) / (pairs * 16384);
      end
      for (int k = 0; k < stored; k++) begin
         ug = 0;
         ig = 0;
         if (!err) begin
            su = sum_mem[k];
            ug = clamp32((su * t14) / 16384);
            ig = clamp32((t14 * longint'(user_mem[k]) +
                          c14 * (su - longint'(item_mem[k]))) / 16384);
         end
         g.index = k[5:0];
         g.user_grad = ug[31:0];
         g.item_grad = ig[31:0];
         g.size_err = err;
         g.last = (k + 1 == stored);
         gradients_due.push_back(g);
      end
      dot_sum = 0;
      stored = 0;
   endtask

   // valid stays high between back-to-back elements; dropped only while idling
   task automatic send_element(element_type e);
      int gap;
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {e.rating, e.avg_sim, e.set_size, e.item_f, e.sum_f, e.user_f};
      req_tlast  <= e.last;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_gradients(e);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick16(int pattern);
      case (pattern)
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [21:0] pick22(int pattern);
      case (pattern)
         0: return 22'h1fffff;
         1: return 22'h200000;
         2: return 22'h000000;
         default: return 22'($urandom);
      endcase
   endfunction

   task automatic send_vector(int count, int pattern, logic [7:0] size,
                              logic [15:0] sim, logic [17:0] rate);
      element_type e;
      for (int i = 0; i < count; i++) begin
         e.user_f   = pick16(pattern);
         e.sum_f    = pick22(pattern);
         e.item_f   = pattern < 2 ? pick16(1 - pattern) : pick16(pattern);
         e.set_size = (i == count - 1) ? size : 8'($urandom);
         e.avg_sim  = (i == count - 1) ? sim : 16'($urandom);
         e.rating   = (i == count - 1) ? rate : 18'($urandom);
         e.last     = (i == count - 1);
         send_element(e);
      end
   endtask

   function automatic logic [7:0] random_size();
      case ($urandom_range(0, 9))
         0: return 8'($urandom_range(0, 1));
         1: return 8'd255;
         2: return 8'd2;
         default: return 8'($urandom_range(2, 40));
      endcase
   endfunction

   // result side: random wait per transaction, compare with the oldest expected
   initial begin
      gradient_type got, want;
      int wait_cycles;
      @(negedge clock);
      while (1) begin
         wait_cycles = $urandom_range(0, 7);
         if (wait_cycles != 0) begin
            rsp_tready <= 0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!(rsp_tvalid && !reset)) @(posedge clock);
         got.index     = rsp_tdata[5:0];
         got.user_grad = rsp_tdata[37:6];
         got.item_grad = rsp_tdata[69:38];
         got.size_err  = rsp_tuser;
         got.last      = rsp_tlast;
         if (gradients_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction %h", $time, got);
         end else begin
            want = gradients_due.pop_front();
            if (got.index !== want.index || got.user_grad !== want.user_grad ||
                got.item_grad !== want.item_grad ||
                got.size_err !== want.size_err || got.last !== want.last) begin
               errors++;
               $display("%0t: expected idx %0d ug %0d ig %0d err %b last %b, got idx %0d ug %0d ig %0d err %b last %b",
                        $time, want.index, want.user_grad, want.item_grad,
                        want.size_err, want.last, got.index, got.user_grad,
                        got.item_grad, got.size_err, got.last);
            end
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleMax) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      vector_row_type rows [TableSize];
      int sent;
      int count;
      rows = '{
         '{1,  2, 8'd5,   16'h4000, 18'h04000},
         '{3,  0, 8'd0,   16'h7fff, 18'h1ffff},
         '{2,  1, 8'd1,   16'h8000, 18'h20000},
         '{4,  0, 8'd2,   16'h7fff, 18'h20000},
         '{4,  1, 8'd2,   16'h8000, 18'h1ffff},
         '{5,  0, 8'd255, 16'h8000, 18'h20000},
         '{5,  1, 8'd255, 16'h7fff, 18'h1ffff},
         '{32, 3, 8'd10,  16'h2000, 18'h08000},
         '{36, 3, 8'd3,   16'h7fff, 18'h3c000},
         '{34, 0, 8'd2,   16'h8000, 18'h1ffff},
         '{6,  3, 8'd4,   16'hffff, 18'h3ffff},
         '{2,  2, 8'd2,   16'h0000, 18'h00000},
         '{3,  1, 8'd3,   16'h8000, 18'h20000},
         '{1,  3, 8'd0,   16'h1234, 18'h01234}
      };
      for (int k = 0; k < Dim; k++) begin
         user_mem[k] = '0;
         sum_mem[k]  = '0;
         item_mem[k] = '0;
      end
      dot_sum = 0;
      stored = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      for (int i = 0; i < TableSize; i++)
         send_vector(rows[i].count, rows[i].pattern, rows[i].set_size,
                     rows[i].avg_sim, rows[i].rating);
      req_tvalid <= 0;

      // sender holds off until every pending gradient has drained
      while (gradients_due.size() != 0) @(negedge clock);

      sent = 0;
      while (sent < 180) begin
         if ($urandom_range(0, 15) == 0) count = $urandom_range(30, 36);
         else count = $urandom_range(1, 8);
         send_vector(count, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 3,
                     random_size(), 16'($urandom), 18'($urandom));
         sent += count;
      end
      req_tvalid <= 0;

      while (gradients_due.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
